/* src/sorted_list_insert_delete_core_defines.svh */
// Assertion macros used by the checker file of the sorted list core.
`ifndef SORTED_LIST_INSERT_DELETE_CORE_DEFINES_SVH
`define SORTED_LIST_INSERT_DELETE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SLID_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sorted list core: check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define SLID_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted list core: check failed");

`endif

/* src/slid_pkg.sv */
// Types and constants of the sorted list insert/delete core.
`timescale 1ns / 1ps
`default_nettype none

package slid_pkg;

  localparam int unsigned CAPACITY  = 16;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned COUNT_W   = 5;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned IN_DATA_W = 32;
  localparam int unsigned OUT_DATA_W = 40;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_DELETE = 1'b1
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  // Command broadcast to every cell in the row.
  typedef struct packed {
    logic                      ins_en;
    logic                      del_en;
    logic signed [VALUE_W-1:0] value;
  } cell_cmd_t;

  // Compare results a cell shows to its neighbors and to the control logic.
  typedef struct packed {
    logic ins_cond;   // slot is free or holds a value larger than the request
    logic del_ge;     // slot is occupied and holds a value not below the request
    logic del_first;  // first occupied slot that equals the request
  } cell_flags_t;

endpackage

`default_nettype wire

/* src/slid_cell.sv */
// One slot of the sorted row: holds a value and shifts toward either neighbor.
`timescale 1ns / 1ps
`default_nettype none

module slid_cell #(
  parameter int unsigned Index  = 0,
  parameter int unsigned CountW = 5
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic [CountW-1:0]                   count_i,
  input  wire slid_pkg::cell_cmd_t                 cmd_i,
  input  wire logic signed [slid_pkg::VALUE_W-1:0] left_value_i,
  input  wire slid_pkg::cell_flags_t               left_flags_i,
  input  wire logic signed [slid_pkg::VALUE_W-1:0] right_value_i,
  output logic signed [slid_pkg::VALUE_W-1:0]      value_o,
  output slid_pkg::cell_flags_t                    flags_o
);

  logic signed [slid_pkg::VALUE_W-1:0] value_q;
  logic signed [slid_pkg::VALUE_W-1:0] value_d;
  logic signed [slid_pkg::VALUE_W-1:0] req_value;
  logic                                occupied;
  logic                                upd_en;

  // Slots below the entry count hold the sorted entries.
  assign occupied  = count_i > CountW'(Index);
  assign req_value = cmd_i.value;

  always_comb begin
    flags_o.ins_cond  = !occupied || (req_value < value_q);
    flags_o.del_ge    = occupied && !(value_q < req_value);
    flags_o.del_first = occupied && (value_q == req_value) && !left_flags_i.del_ge;
  end

  // Insert: slots from the insert point on move one place up, the insert point
  // takes the new value. Delete: slots from the match on take their upper neighbor.
  always_comb begin
    value_d = value_q;
    upd_en  = 1'b0;
    if (cmd_i.ins_en && flags_o.ins_cond) begin
      upd_en  = 1'b1;
      value_d = left_flags_i.ins_cond ? left_value_i : req_value;
    end else if (cmd_i.del_en && flags_o.del_ge) begin
      upd_en  = 1'b1;
      value_d = right_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
    end else if (upd_en) begin
      value_q <= value_d;
    end
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

/* src/sorted_list_insert_delete_core.sv */
// Sorted list core: a row of compare-and-shift cells with a registered result.
// The block keeps up to CAPACITY signed 32-bit values in ascending order. A
// request with tuser 0 inserts the value after any equal entries; tuser 1
// deletes one equal entry. Each request yields one result in the cycle after it
// is accepted, and a new request can be taken every cycle while the result side
// keeps up. The cycle is set by one compare in each cell plus an OR over the
// cells' match flags that decides whether a delete shifts the row. The result
// shows the status in tuser and the count, smallest value and empty flag in
// tdata; the value slots need no clearing after reset.
`timescale 1ns / 1ps
`default_nettype none

module sorted_list_insert_delete_core #(
  parameter int unsigned CAPACITY = slid_pkg::CAPACITY
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [slid_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // [31:0] value
  input  wire logic                               s_axis_tuser,  // [0] func
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [4:0] count, [36:5] smallest, [37] is_empty, [39:38] zero
  output logic [slid_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
  output logic [slid_pkg::STATUS_W-1:0]           m_axis_tuser   // [1:0] status
);

  localparam int unsigned CountW = $clog2(CAPACITY + 1);

  logic [CountW-1:0]         count_q;
  logic [CountW-1:0]         count_d;
  slid_pkg::status_e         status_q;
  slid_pkg::status_e         status_d;
  logic                      out_valid_q;
  logic                      out_valid_d;
  logic                      in_acc;
  logic                      is_insert;
  logic                      full;
  logic                      found;
  logic [CAPACITY-1:0]       first_vec;
  slid_pkg::cell_cmd_t       cmd;
  slid_pkg::cell_flags_t     flags   [CAPACITY];
  logic signed [slid_pkg::VALUE_W-1:0] values [CAPACITY];
  logic signed [slid_pkg::VALUE_W-1:0] smallest;
  logic                      is_empty;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign is_insert     = s_axis_tuser == slid_pkg::FUNC_INSERT;
  assign full          = count_q == CountW'(CAPACITY);

  // At most one cell flags itself as the first match.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      first_vec[i] = flags[i].del_first;
    end
  end
  assign found = |first_vec;

  always_comb begin
    cmd.value  = s_axis_tdata[slid_pkg::VALUE_W-1:0];
    cmd.ins_en = in_acc && is_insert && !full;
    cmd.del_en = in_acc && !is_insert && found;
  end

  generate
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [slid_pkg::VALUE_W-1:0] left_value;
      logic signed [slid_pkg::VALUE_W-1:0] right_value;
      slid_pkg::cell_flags_t               left_flags;

      if (g == 0) begin : g_first
        assign left_value = values[g];
        assign left_flags = '0;
      end else begin : g_inner
        assign left_value = values[g-1];
        assign left_flags = flags[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
        assign right_value = values[g];
      end else begin : g_notlast
        assign right_value = values[g+1];
      end

      slid_cell #(
        .Index  (g),
        .CountW (CountW)
      ) u_cell (
        .clk_i         (clk_i),
        .rst_ni        (rst_ni),
        .count_i       (count_q),
        .cmd_i         (cmd),
        .left_value_i  (left_value),
        .left_flags_i  (left_flags),
        .right_value_i (right_value),
        .value_o       (values[g]),
        .flags_o       (flags[g])
      );
    end
  endgenerate

  always_comb begin
    count_d  = count_q;
    status_d = status_q;
    if (in_acc) begin
      if (is_insert) begin
        if (full) begin
          status_d = slid_pkg::ST_FULL;
        end else begin
          status_d = slid_pkg::ST_DONE;
          count_d  = count_q + CountW'(1);
        end
      end else begin
        if (found) begin
          status_d = slid_pkg::ST_DONE;
          count_d  = count_q - CountW'(1);
        end else begin
          status_d = slid_pkg::ST_NOT_FOUND;
        end
      end
    end
  end

  assign out_valid_d = in_acc || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      status_q    <= slid_pkg::ST_DONE;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The row only changes when a request is taken, which is also when the
  // pending result leaves, so the result can be read straight from the state.
  assign is_empty = count_q == '0;
  assign smallest = is_empty ? '0 : values[0];

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {2'b00, is_empty, smallest, slid_pkg::COUNT_W'(count_q)};

endmodule

`default_nettype wire

/* src/slid_checker.sv */
// Port-level checks of the sorted list core and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_list_insert_delete_core_defines.svh"

module slid_checker #(
  parameter int unsigned CAPACITY = slid_pkg::CAPACITY
) (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           s_axis_tvalid,
  input wire logic                           s_axis_tready,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [slid_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic [slid_pkg::STATUS_W-1:0]  m_axis_tuser
);

  logic [slid_pkg::COUNT_W-1:0] res_count;
  logic [slid_pkg::VALUE_W-1:0] res_smallest;
  logic                         res_empty;

  assign res_count    = m_axis_tdata[4:0];
  assign res_smallest = m_axis_tdata[36:5];
  assign res_empty    = m_axis_tdata[37];

  // A result that is held back keeps its contents.
  `SLID_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // Every accepted request shows its result in the next cycle.
  `SLID_ASSERT_NEXT(a_result_follows, s_axis_tvalid && s_axis_tready, m_axis_tvalid)

  // With no result pending the core always takes a request.
  `SLID_ASSERT_IMPL(a_ready_when_drained, !m_axis_tvalid, s_axis_tready)

  // An empty table reports no entries and a zero smallest value.
  `SLID_ASSERT_IMPL(a_empty_fields, m_axis_tvalid && res_empty, res_count == '0 && res_smallest == '0)

  // A rejected insert only happens on a full table.
  `SLID_ASSERT_IMPL(a_full_status, m_axis_tvalid && m_axis_tuser == slid_pkg::ST_FULL, !res_empty && res_count == slid_pkg::COUNT_W'(CAPACITY))

endmodule

bind sorted_list_insert_delete_core slid_checker #(.CAPACITY(CAPACITY)) u_slid_checker (.*);

`default_nettype wire
